[hw/rtl/bdqs_pkg.sv]
// Shared types and constants for the byte deque with search.
// Depends on nothing; imported by bdqs_ram users and byte_deque_with_search.
package bdqs_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 4;
	localparam int OCNT_W = 5;

	typedef enum logic [2:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_REM_FRONT = 3'd2,
		MODE_REM_BACK  = 3'd3,
		MODE_SEARCH    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  position;
		logic [OCNT_W-1:0] count;
	} rsp_t;

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] slot);
		logic [IDX_W-1:0] r;
		if (slot == IDX_W'(DEPTH - 1))
			r = '0;
		else
			r = slot + IDX_W'(1);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] slot);
		logic [IDX_W-1:0] r;
		if (slot == '0)
			r = IDX_W'(DEPTH - 1);
		else
			r = slot - IDX_W'(1);
		return r;
	endfunction

endpackage

[hw/rtl/byte_deque_with_search.sv]
// Top level of the byte deque: ring pointers, operation sequencer and store.
// Depends on bdqs_pkg and bdqs_ram.

// Bounded double-ended byte queue with a search from the front. Start a
// transaction by raising start with req while busy is low; the result shows
// on rsp for exactly one cycle with done high and cannot be held off. Inserts,
// removes, unused modes and a search of an empty queue give their result in the
// cycle after acceptance, and a new transaction may be started in that same
// cycle. A search reads one stored byte per cycle through the single read
// port of the store: a hit is reported once the byte at its position has
// been compared, a miss once every held byte has been compared, with busy
// high meanwhile. Store contents are undefined after reset; only held entries
// are ever compared.
module byte_deque_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bdqs_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output bdqs_pkg::rsp_t rsp
);
	import bdqs_pkg::*;

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_slot_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [7:0]       key_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             hit;
	logic             last;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W:0]   back_sum;
	logic [IDX_W-1:0] back_slot;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic             re;
	logic [IDX_W-1:0] raddr;
	logic [7:0]       rdata;

	assign busy = (state_q == ST_SCAN);
	assign done = done_q;
	assign rsp = rsp_q;

	assign accept = start && !busy;
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign hit = (rdata == key_q);
	assign last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);
	assign front_dec = slot_dec(front_q);
	assign front_inc = slot_inc(front_q);
	assign back_sum = (IDX_W+1)'(front_q) + (IDX_W+1)'(count_q);
	assign back_slot = (back_sum >= (IDX_W+1)'(DEPTH)) ?
		IDX_W'(back_sum - (IDX_W+1)'(DEPTH)) : IDX_W'(back_sum);

	always_comb begin
		we = 1'b0;
		waddr = front_dec;
		re = 1'b0;
		raddr = front_q;
		if (accept) begin
			unique case (req.mode)
				MODE_INS_FRONT: begin
					we = !full;
					waddr = front_dec;
				end
				MODE_INS_BACK: begin
					we = !full;
					waddr = back_slot;
				end
				MODE_SEARCH: begin
					re = !empty;
					raddr = front_q;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			re = 1'b1;
			raddr = scan_slot_q;
		end
	end

	bdqs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.data),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			count_q <= '0;
			scan_slot_q <= '0;
			scan_idx_q <= '0;
			key_q <= '0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b1;
						rsp_q.status <= STAT_OK;
						rsp_q.position <= '0;
						rsp_q.count <= OCNT_W'(count_q);
						unique case (req.mode)
							MODE_INS_FRONT: begin
								if (full) begin
									rsp_q.status <= STAT_FULL;
								end else begin
									front_q <= front_dec;
									count_q <= count_q + CNT_W'(1);
									rsp_q.count <= OCNT_W'(count_q + CNT_W'(1));
								end
							end
							MODE_INS_BACK: begin
								if (full) begin
									rsp_q.status <= STAT_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
									rsp_q.count <= OCNT_W'(count_q + CNT_W'(1));
								end
							end
							MODE_REM_FRONT: begin
								if (empty) begin
									rsp_q.status <= STAT_EMPTY;
								end else begin
									front_q <= front_inc;
									count_q <= count_q - CNT_W'(1);
									rsp_q.count <= OCNT_W'(count_q - CNT_W'(1));
								end
							end
							MODE_REM_BACK: begin
								if (empty) begin
									rsp_q.status <= STAT_EMPTY;
								end else begin
									count_q <= count_q - CNT_W'(1);
									rsp_q.count <= OCNT_W'(count_q - CNT_W'(1));
								end
							end
							MODE_SEARCH: begin
								if (empty) begin
									rsp_q.status <= STAT_EMPTY;
								end else begin
									done_q <= 1'b0;
									key_q <= req.data;
									scan_idx_q <= '0;
									scan_slot_q <= front_inc;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								rsp_q.status <= STAT_OK;
							end
						endcase
					end
				end
				ST_SCAN: begin
					priority if (hit) begin
						done_q <= 1'b1;
						rsp_q.status <= STAT_OK;
						rsp_q.position <= POS_W'(scan_idx_q);
						rsp_q.count <= OCNT_W'(count_q);
						state_q <= ST_IDLE;
					end else if (last) begin
						done_q <= 1'b1;
						rsp_q.status <= STAT_NOT_FOUND;
						rsp_q.position <= '0;
						rsp_q.count <= OCNT_W'(count_q);
						state_q <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
						scan_slot_q <= slot_inc(scan_slot_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe during search scan");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("held count exceeds depth");

	a_short_op_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode != MODE_SEARCH || empty)) |=> (done && !busy))
		else $error("non-scanning transaction did not finish in one cycle");

	a_full_refusal_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_FULL) |-> (rsp.count == OCNT_W'(DEPTH)))
		else $error("insert refused while not full");

endmodule

[hw/rtl/bdqs_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
module bdqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[bench/byte_deque_with_search_chk.sv]
// Transaction checker for byte_deque_with_search: tracks the deque state, predicts each result
// and compares it field by field. Depends on bdqs_pkg.
// Hands its failure count and the number of pending results to the bench top.
module byte_deque_with_search_chk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  bdqs_pkg::req_t  req,
	input  logic            done,
	input  bdqs_pkg::rsp_t  rsp,
	output int              fail_count,
	output int              pending
);
	import bdqs_pkg::*;

	logic [7:0]        ring_bytes [DEPTH];
	logic [3:0]        ring_front;
	logic [4:0]        ring_held;
	rsp_t              expected_rsps [$];

	function automatic rsp_t deque_apply(input req_t r);
		rsp_t res;
		logic [3:0] slot;
		res.status   = STAT_OK;
		res.position = '0;
		case (r.mode)
			MODE_INS_FRONT: begin
				if (ring_held >= 5'(DEPTH)) begin
					res.status = STAT_FULL;
				end else begin
					ring_front = ring_front - 4'd1;
					ring_bytes[ring_front] = r.data;
					ring_held = ring_held + 5'd1;
				end
			end
			MODE_INS_BACK: begin
				if (ring_held >= 5'(DEPTH)) begin
					res.status = STAT_FULL;
				end else begin
					slot = ring_front + ring_held[3:0];
					ring_bytes[slot] = r.data;
					ring_held = ring_held + 5'd1;
				end
			end
			MODE_REM_FRONT: begin
				if (ring_held == '0) begin
					res.status = STAT_EMPTY;
				end else begin
					ring_front = ring_front + 4'd1;
					ring_held = ring_held - 5'd1;
				end
			end
			MODE_REM_BACK: begin
				if (ring_held == '0)
					res.status = STAT_EMPTY;
				else
					ring_held = ring_held - 5'd1;
			end
			MODE_SEARCH: begin
				if (ring_held == '0) begin
					res.status = STAT_EMPTY;
				end else begin
					res.status = STAT_NOT_FOUND;
					for (int i = 0; i < DEPTH; i++) begin
						slot = ring_front + 4'(i);
						if (i < int'(ring_held) && res.status == STAT_NOT_FOUND &&
								ring_bytes[slot] == r.data) begin
							res.status   = STAT_OK;
							res.position = 4'(i);
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.count = ring_held;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			ring_front = '0;
			ring_held  = '0;
			for (int i = 0; i < DEPTH; i++)
				ring_bytes[i] = '0;
			expected_rsps.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (done) begin
				if (expected_rsps.size() == 0) begin
					$error("result with no transaction outstanding: status %0d position %0d count %0d",
						rsp.status, rsp.position, rsp.count);
					fail_count = fail_count + 1;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						fail_count = fail_count + 1;
					end
					if (rsp.position !== want.position) begin
						$error("position: expected %0d, actual %0d", want.position, rsp.position);
						fail_count = fail_count + 1;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, rsp.count);
						fail_count = fail_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_rsps.push_back(deque_apply(req));
			pending = expected_rsps.size();
		end
	end

endmodule

[bench/byte_deque_with_search_tb.sv]
// Bench top for byte_deque_with_search: clock, reset, directed and random transactions.
// Depends on bdqs_pkg, byte_deque_with_search and byte_deque_with_search_chk.
module byte_deque_with_search_tb;
	import bdqs_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int BLOCKS = 26;
	localparam int BLOCK_LEN = 40;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       done;
	req_t       req;
	rsp_t       rsp;
	int         fail_count;
	int         pending;
	bit         idle_on;
	int         fill_bias;
	logic [7:0] recent_bytes [$];

	byte_deque_with_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	byte_deque_with_search_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_op(input logic [2:0] mode, input logic [7:0] data);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= '{mode: mode, data: data};
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (mode == MODE_INS_FRONT || mode == MODE_INS_BACK) begin
			recent_bytes.push_back(data);
			if (recent_bytes.size() > 32)
				void'(recent_bytes.pop_front());
		end
	endtask

	function automatic logic [2:0] pick_mode(input int bias);
		int roll;
		int ins_pct;
		int rem_pct;
		roll    = $urandom_range(0, 99);
		ins_pct = (bias == 0) ? 60 : (bias == 1) ? 20 : 40;
		rem_pct = (bias == 0) ? 20 : (bias == 1) ? 60 : 35;
		if (roll < 2)
			return MODE_SPARE_LO + 3'($urandom_range(0, 2));
		if (roll < 2 + ins_pct)
			return $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
		if (roll < 2 + ins_pct + rem_pct)
			return $urandom_range(0, 1) ? MODE_REM_FRONT : MODE_REM_BACK;
		return MODE_SEARCH;
	endfunction

	function automatic logic [7:0] pick_data(input logic [2:0] mode);
		if (mode == MODE_SEARCH && recent_bytes.size() > 0 && $urandom_range(0, 9) < 7)
			return recent_bytes[$urandom_range(0, recent_bytes.size() - 1)];
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [2:0] mode;
		start   = 1'b0;
		req     = '0;
		arst_n  = 1'b0;
		idle_on = 1'b1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_op(MODE_SEARCH, 8'h00);
		send_op(MODE_REM_FRONT, 8'hFF);
		send_op(MODE_REM_BACK, 8'h00);
		send_op(MODE_SPARE_LO, 8'hFF);
		send_op(MODE_SPARE_MID, 8'h00);
		send_op(MODE_SPARE_HI, 8'hFF);
		send_op(MODE_INS_BACK, 8'h00);
		send_op(MODE_INS_FRONT, 8'hFF);
		send_op(MODE_SEARCH, 8'h00);
		send_op(MODE_SEARCH, 8'h5A);
		for (int i = 0; i < 13; i++)
			send_op((i % 2) ? MODE_INS_BACK : MODE_INS_FRONT, 8'h10 + 8'(i));
		send_op(MODE_INS_BACK, 8'hC3);
		send_op(MODE_INS_FRONT, 8'h33);
		send_op(MODE_INS_BACK, 8'hCC);
		send_op(MODE_SEARCH, 8'hC3);

		for (int blk = 0; blk < BLOCKS; blk++) begin
			fill_bias = $urandom_range(0, 2);
			idle_on   = $urandom_range(0, 3) != 0;
			if (blk % 8 == 4) begin
				start <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			for (int k = 0; k < BLOCK_LEN; k++) begin
				mode = pick_mode(fill_bias);
				send_op(mode, pick_data(mode));
			end
		end

		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DEPTH + 4) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
